>>> sv/deq_pkg.sv
// Shared constants and types for the deduplicating event queue.
package deq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CODE_W = 8;

  localparam logic [CODE_W-1:0] EMPTY_CODE = 8'hFF;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  // Access to the entry store for one cycle.
  typedef struct packed {
    logic              we;
    logic              clr;
    logic [IDX_W-1:0]  waddr;
    logic [CODE_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } deq_store_cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_SCAN    = 5'b00010,
    ST_CHECK   = 5'b00100,
    ST_POP_RD  = 5'b01000,
    ST_POP_OUT = 5'b10000
  } deq_state_t;

endpackage

>>> sv/deq_store.sv
// Entry store: one write port, one registered read port, per-entry valid bits.
module deq_store
  import deq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  deq_store_cmd_t    cmd,
  output logic [CODE_W-1:0] rd_code
);

  logic [CODE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic [CODE_W-1:0] rd_data_r;
  logic              rd_vld_r;

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.waddr] <= cmd.wdata;
    end
    rd_data_r <= mem[cmd.raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.we) begin
        vld_r[cmd.waddr] <= 1'b1;
      end else if (cmd.clr) begin
        vld_r[cmd.waddr] <= 1'b0;
      end
      rd_vld_r <= vld_r[cmd.raddr];
    end
  end

  // an entry never written, or cleared by a pop, reads as empty
  assign rd_code = rd_vld_r ? rd_data_r : EMPTY_CODE;

endmodule

>>> sv/dedup_event_queue.sv
// Deduplicating event queue: top level with scan/pop sequencer.
//
//   channel  ports                                   handshake
//   input    in_mode, in_event_code                  start & !busy
//   result   out_event_out, out_stored               out_valid, one cycle
//
// A push scans entries 0..write index one compare per cycle through the
// store's single read port, then decides in ST_CHECK and strobes the result.
// A pop runs ST_POP_RD then ST_POP_OUT; an empty pop is answered from ST_IDLE.
// Reset marks every entry empty and zeroes both counts; no clearing pass.
// busy stays high until the result is registered; the receiver cannot stall.
module dedup_event_queue
  import deq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_mode,
  input  logic [CODE_W-1:0] in_event_code,
  output logic              out_valid,
  output logic [CODE_W-1:0] out_event_out,
  output logic              out_stored
);

  deq_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  wc_r, wc_nxt;
  logic [CNT_W-1:0]  rc_r, rc_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  pop_addr_r, pop_addr_nxt;
  logic              pop_clr_r, pop_clr_nxt;
  logic              dup_r, dup_nxt;
  logic              cmp_v_r, cmp_v_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0] out_event_r, out_event_nxt;
  logic              out_stored_r, out_stored_nxt;

  deq_store_cmd_t    cmd;
  logic [CODE_W-1:0] rd_code;
  logic              accept;
  logic              hit;

  deq_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .rd_code (rd_code)
  );

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign hit    = cmp_v_r && (rd_code == code_r);

  always_comb begin
    state_nxt      = state_r;
    wc_nxt         = wc_r;
    rc_nxt         = rc_r;
    idx_nxt        = idx_r;
    pop_addr_nxt   = pop_addr_r;
    pop_clr_nxt    = pop_clr_r;
    dup_nxt        = dup_r;
    cmp_v_nxt      = 1'b0;
    code_nxt       = code_r;
    out_valid_nxt  = 1'b0;
    out_event_nxt  = out_event_r;
    out_stored_nxt = out_stored_r;

    cmd       = '0;
    cmd.raddr = (state_r == ST_SCAN) ? idx_r : pop_addr_r;
    cmd.waddr = (state_r == ST_CHECK) ? wc_r[IDX_W-1:0] : pop_addr_r;
    cmd.wdata = code_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          code_nxt = in_event_code;
          if (in_mode == MODE_PUSH) begin
            if (wc_r >= CNT_W'(DEPTH)) begin
              wc_nxt = '0;
            end
            idx_nxt   = '0;
            dup_nxt   = 1'b0;
            state_nxt = ST_SCAN;
          end else if (rc_r >= CNT_W'(DEPTH)) begin
            // read count at depth: return entry 0, leave it in place
            rc_nxt       = '0;
            pop_addr_nxt = '0;
            pop_clr_nxt  = 1'b0;
            state_nxt    = ST_POP_RD;
          end else if (rc_r >= wc_r) begin
            rc_nxt         = '0;
            wc_nxt         = '0;
            out_valid_nxt  = 1'b1;
            out_event_nxt  = EMPTY_CODE;
            out_stored_nxt = 1'b0;
          end else begin
            pop_addr_nxt = rc_r[IDX_W-1:0];
            pop_clr_nxt  = 1'b1;
            rc_nxt       = rc_r + CNT_W'(1);
            state_nxt    = ST_POP_RD;
          end
        end
      end
      ST_SCAN: begin
        cmp_v_nxt = 1'b1;
        if (hit) begin
          dup_nxt = 1'b1;
        end
        if (CNT_W'(idx_r) == wc_r) begin
          state_nxt = ST_CHECK;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_CHECK: begin
        // last compare (the write slot itself) lands here
        out_valid_nxt  = 1'b1;
        out_event_nxt  = EMPTY_CODE;
        out_stored_nxt = !(dup_r || hit);
        if (!(dup_r || hit)) begin
          cmd.we = 1'b1;
          wc_nxt = wc_r + CNT_W'(1);
        end
        state_nxt = ST_IDLE;
      end
      ST_POP_RD: begin
        state_nxt = ST_POP_OUT;
      end
      ST_POP_OUT: begin
        cmd.clr        = pop_clr_r;
        out_valid_nxt  = 1'b1;
        out_event_nxt  = rd_code;
        out_stored_nxt = 1'b0;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wc_r        <= '0;
      rc_r        <= '0;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wc_r        <= wc_nxt;
      rc_r        <= rc_nxt;
      cmp_v_r     <= cmp_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pop_addr_r   <= pop_addr_nxt;
    pop_clr_r    <= pop_clr_nxt;
    dup_r        <= dup_nxt;
    code_r       <= code_nxt;
    out_event_r  <= out_event_nxt;
    out_stored_r <= out_stored_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_event_out = out_event_r;
  assign out_stored    = out_stored_r;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for dedup_event_queue: directed and randomized push/pop traffic.
module tb_top;
  import deq_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = DEPTH + 4;

  typedef struct packed {
    logic [CODE_W-1:0] event_out;
    logic              stored;
  } deq_result_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_mode;
  logic [CODE_W-1:0] in_event_code;
  logic              out_valid;
  logic [CODE_W-1:0] out_event_out;
  logic              out_stored;

  // Shadow copy of the queue contents and counts
  logic [CODE_W-1:0] model_entries [DEPTH];
  int                model_wr_cnt;
  int                model_rd_cnt;

  deq_result_t       pending_results [$];
  int                events_sent;
  int                mismatches = 0;
  int                quiet_cycles = 0;

  dedup_event_queue DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_event_code (in_event_code),
    .out_valid     (out_valid),
    .out_event_out (out_event_out),
    .out_stored    (out_stored)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic deq_result_t model_apply(logic mode, logic [CODE_W-1:0] code);
    deq_result_t res;
    logic        hit;
    res.event_out = EMPTY_CODE;
    res.stored = 1'b0;
    hit = 1'b0;
    if (mode == MODE_PUSH) begin
      if (model_wr_cnt >= DEPTH) model_wr_cnt = 0;
      // scan includes the slot about to be written
      for (int i = 0; i <= model_wr_cnt && i < DEPTH; i++) begin
        if (model_entries[i] == code) hit = 1'b1;
      end
      if (!hit) begin
        model_entries[model_wr_cnt] = code;
        model_wr_cnt++;
        res.stored = 1'b1;
      end
    end else begin
      if (model_rd_cnt >= DEPTH) begin
        // read count at depth: return entry 0, leave it in place
        model_rd_cnt = 0;
        res.event_out = model_entries[0];
      end else if (model_rd_cnt >= model_wr_cnt) begin
        model_rd_cnt = 0;
        model_wr_cnt = 0;
      end else begin
        res.event_out = model_entries[model_rd_cnt];
        model_entries[model_rd_cnt] = EMPTY_CODE;
        model_rd_cnt++;
      end
    end
    return res;
  endfunction

  // Drive one event and hold it until the block takes the transfer.
  task automatic send_event(logic mode, logic [CODE_W-1:0] code);
    @(negedge clk);
    start <= 1'b1;
    in_mode <= mode;
    in_event_code <= code;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(model_apply(mode, code));
    events_sent++;
  endtask

  task automatic idle_gap(int pct);
    while ($urandom_range(99) < pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic gapped_send(int pct, logic mode, logic [CODE_W-1:0] code);
    idle_gap(pct);
    send_event(mode, code);
  endtask

  task automatic release_start();
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic test_empty_pop();
    send_event(MODE_POP, 8'h00);
  endtask

  task automatic test_push_dedup();
    send_event(MODE_PUSH, 8'h00);
    send_event(MODE_PUSH, 8'h00);
    send_event(MODE_PUSH, EMPTY_CODE);  // hits the empty slot at the write index
    send_event(MODE_PUSH, 8'h80);
    send_event(MODE_POP, 8'hFF);
    send_event(MODE_POP, 8'h7F);
    send_event(MODE_POP, 8'h00);
  endtask

  task automatic test_wrap_overwrite();
    logic [3:0] idx;
    for (int i = 0; i < DEPTH; i++) begin
      idx = i[3:0];
      send_event(MODE_PUSH, {idx, ~idx});
    end
    // write count wraps; entry 0 is not empty so 0xFF gets stored
    send_event(MODE_PUSH, EMPTY_CODE);
    send_event(MODE_PUSH, 8'h1E);       // duplicate of unpopped entry 1
    send_event(MODE_PUSH, 8'h2D);       // overwrites entry 1
    send_event(MODE_POP, 8'h00);
    send_event(MODE_POP, 8'h00);
    send_event(MODE_POP, 8'h00);
  endtask

  // Drain, fill to depth, then pop DEPTH to DEPTH + 2 times so the read count can wrap.
  task automatic seq_fill_drain(int pct);
    int tries;
    tries = 0;
    while (!(model_rd_cnt == 0 && model_wr_cnt == 0) && tries < 24) begin
      gapped_send(pct, MODE_POP, CODE_W'($urandom));
      tries++;
    end
    tries = 0;
    while (model_wr_cnt != DEPTH && tries < 40) begin
      gapped_send(pct, MODE_PUSH, CODE_W'($urandom));
      tries++;
    end
    repeat ($urandom_range(DEPTH + 2, DEPTH)) gapped_send(pct, MODE_POP, CODE_W'($urandom));
  endtask

  // Mixed pushes and pops; pushes draw from a tiny code pool so duplicates are common.
  task automatic seq_mixed_burst(int pct);
    logic [CODE_W-1:0] pool [4];
    logic [CODE_W-1:0] code;
    foreach (pool[i]) pool[i] = CODE_W'($urandom);
    repeat ($urandom_range(12, 1)) begin
      code = ($urandom_range(7) == 0) ? EMPTY_CODE : pool[$urandom_range(3)];
      if ($urandom_range(9) < 6) gapped_send(pct, MODE_PUSH, code);
      else gapped_send(pct, MODE_POP, CODE_W'($urandom));
    end
  endtask

  task automatic seq_noise(int pct);
    repeat ($urandom_range(8, 1)) gapped_send(pct, 1'($urandom), CODE_W'($urandom));
  endtask

  task automatic test_random_traffic();
    int idle_pct [4] = '{0, 79, 0, 38};  // receiver cannot stall: only input gaps vary; the 0% phases run unthrottled
    int phase_end;
    int pick;
    foreach (idle_pct[p]) begin
      phase_end = events_sent + 160;
      while (events_sent < phase_end) begin
        pick = $urandom_range(9);
        if (pick < 3) seq_fill_drain(idle_pct[p]);
        else if (pick < 7) seq_mixed_burst(idle_pct[p]);
        else seq_noise(idle_pct[p]);
      end
      release_start();
    end
  endtask

  always @(posedge clk) begin
    deq_result_t exp_res;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: event_out %h stored %b", out_event_out, out_stored);
        mismatches++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_event_out !== exp_res.event_out) begin
          $error("event_out: expected %h, got %h", exp_res.event_out, out_event_out);
          mismatches++;
        end
        if (out_stored !== exp_res.stored) begin
          $error("stored: expected %b, got %b", exp_res.stored, out_stored);
          mismatches++;
        end
      end
    end
  end

  // Ends the run when neither channel has moved a transfer for too long
  always @(posedge clk) begin
    if ((start && !busy && rst_n) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_mode = MODE_PUSH;
    in_event_code = '0;
    events_sent = 0;
    foreach (model_entries[i]) model_entries[i] = EMPTY_CODE;
    model_wr_cnt = 0;
    model_rd_cnt = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_pop();
    test_push_dedup();
    test_wrap_overwrite();
    release_start();
    test_random_traffic();

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/deq_pkg.sv
sv/deq_store.sv
sv/dedup_event_queue.sv
tb/tb_top.sv
